>>> rtl/tps_pkg.sv
// Shared types and constants of the tick process scheduler.
// Item layouts, operation and event codes, register map, control structs.
// No dependencies.
`default_nettype none

package tps_pkg;

    localparam int W_OP   = 2;
    localparam int W_TASK = 4;
    localparam int W_VAL  = 16;
    localparam int W_EV   = 3;
    localparam int W_POL  = 2;
    localparam int W_PCNT = 5;
    localparam int W_ADDR = 4;
    localparam int W_DATA = 32;

    // Operation codes of an input item
    localparam logic [W_OP-1:0] OP_LOAD  = 2'd0;
    localparam logic [W_OP-1:0] OP_TICK  = 2'd1;
    localparam logic [W_OP-1:0] OP_END   = 2'd2;
    localparam logic [W_OP-1:0] OP_STATS = 2'd3;

    // Event codes of a result item
    localparam logic [W_EV-1:0] EV_LOADED   = 3'd0;
    localparam logic [W_EV-1:0] EV_ARRIVED  = 3'd1;
    localparam logic [W_EV-1:0] EV_SELECTED = 3'd2;
    localparam logic [W_EV-1:0] EV_FINISHED = 3'd3;
    localparam logic [W_EV-1:0] EV_IDLE     = 3'd4;
    localparam logic [W_EV-1:0] EV_RUN_END  = 3'd5;
    localparam logic [W_EV-1:0] EV_STATS    = 3'd6;

    // Scheduling policies
    localparam logic [W_POL-1:0] POL_FCFS = 2'd0;
    localparam logic [W_POL-1:0] POL_SRB  = 2'd1;
    localparam logic [W_POL-1:0] POL_RR   = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_POLICY  = 2'd0;
    localparam logic [1:0] REG_QUANTUM = 2'd1;
    localparam logic [1:0] REG_PCOUNT  = 2'd2;

    typedef struct packed {
        logic [W_OP-1:0]   operation;
        logic [W_TASK-1:0] task_index;
        logic [W_VAL-1:0]  arrival;
        logic [W_VAL-1:0]  burst;
    } t_in_item;

    typedef struct packed {
        logic [W_EV-1:0]   event_res;
        logic [W_TASK-1:0] event_task;
        logic [W_VAL-1:0]  event_time;
        logic [W_VAL-1:0]  remaining_burst;
        logic [W_VAL-1:0]  wait_ticks;
        logic [W_VAL-1:0]  turnaround;
        logic              completed;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic emit;
        logic flush;
    } t_evq_ctl;

    typedef struct packed {
        logic can_emit;
        logic flush_ok;
    } t_evq_sts;

endpackage

`default_nettype wire

>>> rtl/tps_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on tps_pkg for the payload structs.
`default_nettype none

interface tps_in_if;
    logic               valid;
    logic               ready;
    tps_pkg::t_in_item  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface tps_out_if;
    logic               valid;
    logic               ready;
    tps_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

>>> rtl/tps_evq.sv
// Result staging: one held event plus the output register.
// Marks the final event of an item as last on flush. Depends on tps_pkg, tps_if.
`default_nettype none

module tps_evq import tps_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_evq_ctl    i_ctl,
    input  wire t_out_item   i_event,
    output t_evq_sts         o_sts,
    tps_out_if.source        o_out
);

    logic      r_p_vld, n_p_vld;
    t_out_item r_p, n_p;
    logic      r_o_vld, n_o_vld;
    t_out_item r_o, n_o;
    logic      o_free;

    assign o_free         = !r_o_vld || o_out.ready;
    assign o_sts.can_emit = !r_p_vld || o_free;
    assign o_sts.flush_ok = !r_p_vld || o_free;

    // Push the held event out when a new one comes or the item ends
    always_comb begin
        n_o_vld = r_o_vld && !o_out.ready;
        n_o     = r_o;
        n_p_vld = r_p_vld;
        n_p     = r_p;
        if (i_ctl.emit && o_sts.can_emit) begin
            if (r_p_vld) begin
                n_o      = r_p;
                n_o.last = 1'b0;
                n_o_vld  = 1'b1;
            end
            n_p     = i_event;
            n_p_vld = 1'b1;
        end else if (i_ctl.flush && r_p_vld && o_free) begin
            n_o      = r_p;
            n_o.last = 1'b1;
            n_o_vld  = 1'b1;
            n_p_vld  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_p_vld <= n_p_vld;
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_o <= n_o;
    end

    assign o_out.valid = r_o_vld;
    assign o_out.item  = r_o;

endmodule

`default_nettype wire

>>> rtl/tick_process_scheduler_core.sv
// Tick-driven task scheduler: top level with task memory and sequencer.
// Depends on tps_pkg, tps_if, tps_evq.
//
// Use: input items arrive on i_in (load, tick, end of run, stats read),
// result items leave on o_out, each item's final result carries last.
// Registers policy, quantum and process_count sit on the APB port at
// byte addresses 0, 4 and 8; write them only while the block is idle.
// A tick scans the task memory, one entry per cycle through its single
// read port while no arrival result stalls, followed by one
// read-modify-write of the running task. One item is worked on at a
// time; i_in.ready is high only between items.
// Results pass through a held stage and an output register, so the next
// item is taken while a result waits. A stalled receiver halts the
// sequencer at its next event until the output register frees.
// Reset clears the time counter, ready marks, ring pointers and the
// written marks of the task memory; no clearing pass is needed.
`default_nettype none

module tick_process_scheduler_core import tps_pkg::*; #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tps_in_if.sink                 i_in,
    tps_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [W_ADDR-1:0] paddr,
    input  wire logic [W_DATA-1:0] pwdata,
    output logic      [W_DATA-1:0] prdata,
    output logic                   pready
);

    localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TW   = $clog2(MAX_TASKS + 1);
    localparam int RW   = $clog2(2 * MAX_TASKS);
    localparam int CW_T = (TIME_BITS > W_VAL) ? TIME_BITS : W_VAL;
    localparam logic [TW-1:0] NO_TASK = TW'(MAX_TASKS);

    typedef struct packed {
        logic [W_VAL-1:0]     arrival;
        logic [W_VAL-1:0]     remaining;
        logic [W_VAL-1:0]     wait_cnt;
        logic [TIME_BITS-1:0] end_tick;
    } t_entry;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_LOAD     = 12'b0000_0000_0010,
        S_STATS_RD = 12'b0000_0000_0100,
        S_STATS    = 12'b0000_0000_1000,
        S_FN_RD    = 12'b0000_0001_0000,
        S_FN       = 12'b0000_0010_0000,
        S_END      = 12'b0000_0100_0000,
        S_SCAN0    = 12'b0000_1000_0000,
        S_SCAN     = 12'b0001_0000_0000,
        S_PICK     = 12'b0010_0000_0000,
        S_RUN      = 12'b0100_0000_0000,
        S_FIN      = 12'b1000_0000_0000
    } t_state;

    // Control and configuration state
    t_state               r_state, n_state;
    logic [W_POL-1:0]     r_policy;
    logic [W_VAL-1:0]     r_quantum;
    logic [W_PCNT-1:0]    r_pcount;
    logic [TIME_BITS-1:0] r_tick, n_tick;
    logic                 r_stuck, n_stuck;
    logic [TW-1:0]        r_run, n_run;
    logic [W_VAL-1:0]     r_slice, n_slice;
    logic                 r_done, n_done;
    logic [MAX_TASKS-1:0] r_ready, n_ready;
    logic [MAX_TASKS-1:0] r_loaded, n_loaded;
    logic [MAX_TASKS-1:0] r_inc, n_inc;
    logic [RW-1:0]        r_head, n_head;
    logic [RW-1:0]        r_tail, n_tail;
    logic [IW-1:0]        r_si, n_si;
    logic [TW-1:0]        r_sel, n_sel;
    logic [W_VAL-1:0]     r_best, n_best;
    logic                 r_sel_ev, n_sel_ev;

    // Item payload
    logic [W_OP-1:0]      r_op;
    logic [W_TASK-1:0]    r_idx;
    logic [W_VAL-1:0]     r_arr;
    logic [W_VAL-1:0]     r_burst;

    // Task memory and ready ring
    t_entry               r_mem [MAX_TASKS];
    t_entry               r_rd;
    logic [IW-1:0]        r_rd_addr;
    logic [IW-1:0]        r_ring [MAX_TASKS];
    logic                 mem_we, mem_re;
    logic [IW-1:0]        mem_wa, mem_ra;
    t_entry               mem_wd;
    logic                 enq_en;
    logic [IW-1:0]        enq_val;

    // Derived values
    logic [TW-1:0]        n_eff;
    logic [W_VAL-1:0]     rd_wait;
    logic [TIME_BITS-1:0] rd_end;
    logic [CW_T-1:0]      e_w, a_w;
    logic                 arr_hit, rdy, idx_ok, run_ok, fin, accept, cfg_wr;
    logic [W_VAL-1:0]     key, q1;
    logic [IW-1:0]        run_i;
    logic [RW:0]          ring_cnt;
    logic                 ring_full, ring_empty;
    logic [RW-1:0]        tail_mod, head_mod, tail_inc, head_inc;
    logic [TW-1:0]        deq_task, post_run, pick_run;
    logic                 post_done, reload;
    logic [W_VAL-1:0]     pick_slice;

    t_evq_ctl             evq_ctl;
    t_evq_sts             evq_sts;
    t_out_item            ev;

    assign n_eff   = (int'(r_pcount) > MAX_TASKS) ? TW'(MAX_TASKS) : TW'(r_pcount);
    assign rd_wait = r_loaded[r_rd_addr] ? r_rd.wait_cnt : '0;
    assign rd_end  = r_loaded[r_rd_addr] ? r_rd.end_tick : '0;
    assign e_w     = CW_T'(rd_end);
    assign a_w     = CW_T'(r_rd.arrival);
    assign arr_hit = (CW_T'(r_rd.arrival) == CW_T'(r_tick)) && !r_stuck;
    assign rdy     = r_ready[r_si] || arr_hit;
    assign key     = (r_policy == POL_SRB) ? r_rd.remaining : r_rd.arrival;
    assign q1      = (r_quantum == '0) ? W_VAL'(1) : r_quantum;
    assign idx_ok  = int'(r_idx) < MAX_TASKS;
    assign run_ok  = r_run != NO_TASK;
    assign run_i   = r_run[IW-1:0];
    assign fin     = run_ok && (r_rd.remaining == '0);
    assign accept  = i_in.valid && i_in.ready;

    // Ready ring pointers run over twice the depth to tell full from empty
    assign ring_cnt   = {1'b0, r_tail} - {1'b0, r_head}
                      + ((r_tail < r_head) ? (RW+1)'(2 * MAX_TASKS) : '0);
    assign ring_full  = ring_cnt >= (RW+1)'(MAX_TASKS);
    assign ring_empty = r_head == r_tail;
    assign tail_mod   = (r_tail >= RW'(MAX_TASKS)) ? r_tail - RW'(MAX_TASKS) : r_tail;
    assign head_mod   = (r_head >= RW'(MAX_TASKS)) ? r_head - RW'(MAX_TASKS) : r_head;
    assign tail_inc   = (r_tail == RW'(2 * MAX_TASKS - 1)) ? '0 : r_tail + RW'(1);
    assign head_inc   = (r_head == RW'(2 * MAX_TASKS - 1)) ? '0 : r_head + RW'(1);
    assign deq_task   = (int'(r_ring[head_mod[IW-1:0]]) < MAX_TASKS)
                      ? TW'(r_ring[head_mod[IW-1:0]]) : NO_TASK;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_tick     = r_tick;
        n_stuck    = r_stuck;
        n_run      = r_run;
        n_slice    = r_slice;
        n_done     = r_done;
        n_ready    = r_ready;
        n_loaded   = r_loaded;
        n_inc      = r_inc;
        n_head     = r_head;
        n_tail     = r_tail;
        n_si       = r_si;
        n_sel      = r_sel;
        n_best     = r_best;
        n_sel_ev   = r_sel_ev;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = r_rd;
        mem_re     = 1'b0;
        mem_ra     = '0;
        enq_en     = 1'b0;
        enq_val    = '0;
        evq_ctl    = '0;
        ev         = '0;
        ev.event_time = W_VAL'(r_tick);
        post_run   = r_run;
        post_done  = r_done;
        reload     = 1'b0;
        pick_run   = r_run;
        pick_slice = r_slice;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.item.operation)
                        OP_LOAD:  n_state = S_LOAD;
                        OP_STATS: n_state = S_STATS_RD;
                        default:  n_state = S_FN_RD;
                    endcase
                end
            end

            // Write the entry and report it
            S_LOAD: begin
                evq_ctl.emit  = 1'b1;
                ev.event_res  = EV_LOADED;
                ev.event_task = r_idx;
                if (evq_sts.can_emit) begin
                    if (idx_ok) begin
                        mem_we           = 1'b1;
                        mem_wa           = IW'(r_idx);
                        mem_wd.arrival   = r_arr;
                        mem_wd.remaining = r_burst;
                        mem_wd.wait_cnt  = '0;
                        mem_wd.end_tick  = '0;
                        n_loaded[IW'(r_idx)] = 1'b1;
                        n_ready[IW'(r_idx)]  = 1'b0;
                    end
                    n_state = S_FIN;
                end
            end

            S_STATS_RD: begin
                mem_re  = 1'b1;
                mem_ra  = IW'(r_idx);
                n_state = S_STATS;
            end

            S_STATS: begin
                evq_ctl.emit  = 1'b1;
                ev.event_res  = EV_STATS;
                ev.event_task = r_idx;
                if (idx_ok) begin
                    ev.wait_ticks = rd_wait;
                    ev.turnaround = (e_w >= a_w) ? W_VAL'(e_w - a_w) : '0;
                    ev.completed  = rd_end != '0;
                end
                if (evq_sts.can_emit) begin
                    n_state = S_FIN;
                end
            end

            S_FN_RD: begin
                mem_re  = run_ok;
                mem_ra  = run_i;
                n_state = S_FN;
            end

            // Finish check of the running task
            S_FN: begin
                evq_ctl.emit  = fin;
                ev.event_res  = EV_FINISHED;
                ev.event_task = W_TASK'(r_run);
                if (!fin || evq_sts.can_emit) begin
                    if (fin) begin
                        n_ready[run_i]  = 1'b0;
                        mem_we          = 1'b1;
                        mem_wa          = run_i;
                        mem_wd.wait_cnt = rd_wait;
                        mem_wd.end_tick = r_tick;
                        n_run           = NO_TASK;
                        n_done          = 1'b1;
                        post_run        = NO_TASK;
                        post_done       = 1'b1;
                    end
                    if (r_op == OP_END) begin
                        n_state = S_END;
                    end else begin
                        if (r_policy == POL_RR && r_slice == '0 && !post_done
                            && post_run != NO_TASK) begin
                            enq_en  = 1'b1;
                            enq_val = post_run[IW-1:0];
                        end
                        n_state = S_SCAN0;
                    end
                end
            end

            S_END: begin
                evq_ctl.emit = 1'b1;
                ev.event_res = EV_RUN_END;
                if (evq_sts.can_emit) begin
                    n_state = S_FIN;
                end
            end

            S_SCAN0: begin
                n_sel  = NO_TASK;
                n_best = '0;
                n_inc  = '0;
                n_si   = '0;
                if (n_eff == '0) begin
                    n_state = S_PICK;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = '0;
                    n_state = S_SCAN;
                end
            end

            // Unstalled, an entry a cycle: arrivals, best pick, wait count
            S_SCAN: begin
                evq_ctl.emit  = arr_hit;
                ev.event_res  = EV_ARRIVED;
                ev.event_task = W_TASK'(r_si);
                if (!arr_hit || evq_sts.can_emit) begin
                    if (arr_hit) begin
                        n_ready[r_si] = 1'b1;
                        if (r_policy == POL_RR) begin
                            enq_en  = 1'b1;
                            enq_val = r_si;
                        end
                    end
                    if (r_policy != POL_RR && rdy
                        && (r_sel == NO_TASK || key < r_best)) begin
                        n_sel  = TW'(r_si);
                        n_best = key;
                    end
                    if (rdy && rd_wait != '1) begin
                        mem_we          = 1'b1;
                        mem_wa          = r_si;
                        mem_wd.wait_cnt = rd_wait + W_VAL'(1);
                        mem_wd.end_tick = rd_end;
                        n_inc[r_si]     = 1'b1;
                    end
                    if ((TW'(r_si) + TW'(1)) == n_eff) begin
                        n_state = S_PICK;
                    end else begin
                        n_si    = r_si + IW'(1);
                        mem_re  = 1'b1;
                        mem_ra  = r_si + IW'(1);
                    end
                end
            end

            // Settle the task that runs this tick
            S_PICK: begin
                if (r_policy == POL_RR) begin
                    reload = (r_slice == '0) || r_done;
                    if (reload) begin
                        if (!ring_empty) begin
                            pick_run = deq_task;
                            n_head   = head_inc;
                        end else begin
                            pick_run = NO_TASK;
                        end
                        pick_slice = q1;
                    end
                    n_sel_ev = reload && (pick_run != NO_TASK);
                    if (reload && pick_run != NO_TASK) begin
                        n_done = 1'b0;
                    end
                    if (pick_run != NO_TASK) begin
                        pick_slice = pick_slice - W_VAL'(1);
                    end
                    n_slice = pick_slice;
                end else begin
                    pick_run = r_sel;
                    n_sel_ev = (r_sel != r_run) && (r_sel != NO_TASK);
                end
                n_run   = pick_run;
                mem_re  = pick_run != NO_TASK;
                mem_ra  = pick_run[IW-1:0];
                n_state = S_RUN;
            end

            // Report, burn one tick of burst, undo the running task's wait
            S_RUN: begin
                evq_ctl.emit = !run_ok || r_sel_ev;
                if (!run_ok) begin
                    ev.event_res = EV_IDLE;
                end else begin
                    ev.event_res       = EV_SELECTED;
                    ev.event_task      = W_TASK'(r_run);
                    ev.remaining_burst = r_rd.remaining;
                end
                if (!evq_ctl.emit || evq_sts.can_emit) begin
                    if (run_ok) begin
                        mem_we           = 1'b1;
                        mem_wa           = run_i;
                        mem_wd.remaining = (r_rd.remaining != '0)
                                         ? r_rd.remaining - W_VAL'(1) : '0;
                        mem_wd.wait_cnt  = rd_wait - W_VAL'(r_inc[run_i]);
                        mem_wd.end_tick  = rd_end;
                    end
                    if (r_tick == '1) begin
                        n_stuck = 1'b1;
                    end else begin
                        n_tick = r_tick + TIME_BITS'(1);
                    end
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                evq_ctl.flush = 1'b1;
                if (evq_sts.flush_ok) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (enq_en && !ring_full) begin
            n_tail = tail_inc;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tick   <= '0;
            r_stuck  <= 1'b0;
            r_run    <= NO_TASK;
            r_slice  <= '0;
            r_done   <= 1'b1;
            r_ready  <= '0;
            r_loaded <= '0;
            r_inc    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_si     <= '0;
            r_sel    <= NO_TASK;
            r_best   <= '0;
            r_sel_ev <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tick   <= n_tick;
            r_stuck  <= n_stuck;
            r_run    <= n_run;
            r_slice  <= n_slice;
            r_done   <= n_done;
            r_ready  <= n_ready;
            r_loaded <= n_loaded;
            r_inc    <= n_inc;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_si     <= n_si;
            r_sel    <= n_sel;
            r_best   <= n_best;
            r_sel_ev <= n_sel_ev;
        end
    end

    // Capture the item payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_in.item.operation;
            r_idx   <= i_in.item.task_index;
            r_arr   <= i_in.item.arrival;
            r_burst <= i_in.item.burst;
        end
    end

    // Task memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd      <= r_mem[mem_ra];
            r_rd_addr <= mem_ra;
        end
    end

    // Ready ring storage; drop an enqueue into a full ring
    always_ff @(posedge i_clk) begin
        if (enq_en && !ring_full) begin
            r_ring[tail_mod[IW-1:0]] <= enq_val;
        end
    end

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= POL_FCFS;
            r_quantum <= W_VAL'(1);
            r_pcount  <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_POLICY:  r_policy  <= pwdata[W_POL-1:0];
                REG_QUANTUM: r_quantum <= pwdata[W_VAL-1:0];
                REG_PCOUNT:  r_pcount  <= pwdata[W_PCNT-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_POLICY:  prdata = W_DATA'(r_policy);
            REG_QUANTUM: prdata = W_DATA'(r_quantum);
            REG_PCOUNT:  prdata = W_DATA'(r_pcount);
            default:     prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign i_in.ready = r_state == S_IDLE;

    tps_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (evq_ctl),
        .i_event (ev),
        .o_sts   (evq_sts),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/tps_chk.sv
// Port-level checker of the tick process scheduler, bound to the top level.
// Depends on tps_pkg.
`default_nettype none

module tps_chk import tps_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_item
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    // Items are worked one at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // Reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown after reset");

    // An idle event names no task and carries no burst
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.event_res == EV_IDLE |->
            i_out_item.event_task == '0 && i_out_item.remaining_burst == '0)
        else $error("idle event with task fields");

    // Only a stats event carries statistics
    a_stats_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.event_res != EV_STATS |->
            i_out_item.wait_ticks == '0 && i_out_item.turnaround == '0
            && !i_out_item.completed)
        else $error("statistics outside a stats event");

endmodule

bind tick_process_scheduler_core tps_chk u_tps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.item)
);

`default_nettype wire

>>> tb/sv/tick_process_scheduler_core_test.sv
// Self-checking test of the tick process scheduler: directed table, then random items.
// Depends on tps_pkg, tps_if and tick_process_scheduler_core.
`default_nettype none

module tick_process_scheduler_core_test;
    import tps_pkg::*;

    localparam int NTASK      = 16;
    localparam int NONE       = NTASK;
    localparam int CYCLE_CAP  = 3000000;
    localparam int DRAIN_WAIT = 40;
    localparam int HOLD_LEN   = 500;

    typedef struct {
        logic [W_OP-1:0]   op;
        logic [W_TASK-1:0] idx;
        logic [W_VAL-1:0]  arr;
        logic [W_VAL-1:0]  burst;
        bit                lit;
        logic [W_EV-1:0]   lit_ev;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [W_ADDR-1:0] paddr = '0;
    logic [W_DATA-1:0] pwdata = '0;
    logic [W_DATA-1:0] prdata;
    logic pready;

    tps_in_if  in_ch ();
    tps_out_if out_ch ();

    tick_process_scheduler_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Scheduler state mirrored by the predictor
    logic [15:0] m_arr [NTASK];
    logic [15:0] m_rem [NTASK];
    logic [15:0] m_wait [NTASK];
    logic [15:0] m_end [NTASK];
    bit          m_ready [NTASK];
    logic [3:0]  m_ring [NTASK];
    logic [15:0] m_tick;
    int          m_run;
    logic [15:0] m_slice;
    bit          m_slice_done;
    int          m_head;
    int          m_tail;
    bit          m_stuck;
    logic [1:0]  m_policy;
    logic [15:0] m_quantum;
    logic [4:0]  m_pcount;

    t_out_item event_q[$];
    int        n_posted;
    int        errors = 0;
    int        cycles = 0;
    int        idle_mode = 0;
    bit        hold_req = 0;

    // Record one expected event at the current tick
    function automatic void post(logic [2:0] ev, int tk, logic [15:0] rem,
                                 logic [15:0] wt, logic [15:0] tu, logic c);
        t_out_item r;
        r.event_res       = ev;
        r.event_task      = tk[3:0];
        r.event_time      = m_tick;
        r.remaining_burst = rem;
        r.wait_ticks      = wt;
        r.turnaround      = tu;
        r.completed       = c;
        r.last            = 1'b0;
        event_q.push_back(r);
        n_posted++;
    endfunction

    function automatic void finish_running();
        if (m_run < NTASK && m_rem[m_run] == 0) begin
            post(EV_FINISHED, m_run, 0, 0, 0, 0);
            m_ready[m_run] = 0;
            m_end[m_run] = m_tick;
            m_run = NONE;
            m_slice_done = 1;
        end
    endfunction

    function automatic void run_one(int t);
        if (t < NTASK) begin
            if (m_rem[t] > 0) m_rem[t] = m_rem[t] - 16'd1;
        end else begin
            post(EV_IDLE, 0, 0, 0, 0, 0);
        end
    endfunction

    function automatic void count_waits(int n, int skip);
        for (int i = 0; i < n; i++)
            if (m_ready[i] && i != skip && m_wait[i] != 16'hFFFF)
                m_wait[i] = m_wait[i] + 16'd1;
    endfunction

    function automatic void ring_push(int v);
        if ((m_tail + 32 - m_head) % 32 >= NTASK) return;
        m_ring[m_tail % NTASK] = v[3:0];
        m_tail = (m_tail + 1) % 32;
    endfunction

    function automatic int ring_pop();
        int v;
        if (m_head == m_tail) return NONE;
        v = m_ring[m_head % NTASK];
        m_head = (m_head + 1) % 32;
        return v;
    endfunction

    function automatic void tick_by_priority(int n);
        int sel;
        logic [15:0] best;
        logic [15:0] key;
        sel = NONE;
        best = 0;
        finish_running();
        for (int i = 0; i < n; i++) begin
            if (m_arr[i] == m_tick && !m_stuck) begin
                m_ready[i] = 1;
                post(EV_ARRIVED, i, 0, 0, 0, 0);
            end
            if (m_ready[i]) begin
                key = (m_policy == POL_SRB) ? m_rem[i] : m_arr[i];
                if (sel == NONE || key < best) begin
                    sel = i;
                    best = key;
                end
            end
        end
        count_waits(n, sel);
        if (sel != m_run) begin
            m_run = sel;
            if (sel != NONE) post(EV_SELECTED, sel, m_rem[sel], 0, 0, 0);
        end
        run_one(m_run);
    endfunction

    function automatic void tick_round_robin(int n);
        finish_running();
        if (m_slice == 0 && !m_slice_done && m_run < NTASK) ring_push(m_run);
        for (int i = 0; i < n; i++) begin
            if (m_arr[i] == m_tick && !m_stuck) begin
                m_ready[i] = 1;
                post(EV_ARRIVED, i, 0, 0, 0, 0);
                ring_push(i);
            end
        end
        if (m_slice == 0 || m_slice_done) begin
            m_run = ring_pop();
            if (m_run != NONE) begin
                post(EV_SELECTED, m_run, m_rem[m_run], 0, 0, 0);
                m_slice_done = 0;
            end
            m_slice = (m_quantum != 0) ? m_quantum : 16'd1;
        end
        if (m_run < NTASK && m_slice > 0) m_slice = m_slice - 16'd1;
        run_one(m_run);
        count_waits(n, m_run);
    endfunction

    // Work out the events caused by one accepted item
    function automatic void predict_events(t_in_item it);
        int n;
        logic [15:0] e;
        logic [15:0] a;
        n = (m_pcount > NTASK) ? NTASK : m_pcount;
        n_posted = 0;
        case (it.operation)
            OP_LOAD: begin
                m_arr[it.task_index] = it.arrival;
                m_rem[it.task_index] = it.burst;
                m_wait[it.task_index] = 0;
                m_end[it.task_index] = 0;
                m_ready[it.task_index] = 0;
                post(EV_LOADED, it.task_index, 0, 0, 0, 0);
            end
            OP_TICK: begin
                if (m_policy == POL_RR) tick_round_robin(n);
                else tick_by_priority(n);
                if (m_tick == 16'hFFFF) m_stuck = 1;
                else m_tick = m_tick + 16'd1;
            end
            OP_END: begin
                finish_running();
                post(EV_RUN_END, 0, 0, 0, 0, 0);
            end
            default: begin
                e = m_end[it.task_index];
                a = m_arr[it.task_index];
                post(EV_STATS, it.task_index, 0, m_wait[it.task_index],
                     (e >= a) ? e - a : 16'd0, e != 0);
            end
        endcase
        if (n_posted > 0) event_q[event_q.size()-1].last = 1'b1;
    endfunction

    task automatic report(string field, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", field, got, want, cycles);
        errors++;
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (out_ch.valid && out_ch.ready) begin
            got = out_ch.item;
            if (event_q.size() == 0) begin
                report("unexpected result, event", got.event_res, 0);
            end else begin
                want = event_q.pop_front();
                if (got.event_res != want.event_res) report("event", got.event_res, want.event_res);
                if (got.event_task != want.event_task) report("task", got.event_task, want.event_task);
                if (got.event_time != want.event_time) report("tick", got.event_time, want.event_time);
                if (got.remaining_burst != want.remaining_burst)
                    report("remaining", got.remaining_burst, want.remaining_burst);
                if (got.wait_ticks != want.wait_ticks) report("wait", got.wait_ticks, want.wait_ticks);
                if (got.turnaround != want.turnaround)
                    report("turnaround", got.turnaround, want.turnaround);
                if (got.completed != want.completed) report("completed", got.completed, want.completed);
                if (got.last != want.last) report("last", got.last, want.last);
            end
        end
    end

    // Receiver: random stalls per phase, plus one long hold-off
    int  hold_left = 0;
    bit  hold_used = 0;
    always @(posedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_used = 1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (idle_mode == 2) begin
            out_ch.ready <= ($urandom_range(0, 99) >= 83);
        end else if (idle_mode == 3) begin
            out_ch.ready <= ($urandom_range(0, 99) >= 15);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit sender_gap();
        if (idle_mode == 1) return $urandom_range(0, 99) < 83;
        if (idle_mode == 3) return $urandom_range(0, 99) < 15;
        return 0;
    endfunction

    // Offer one item, hold it until taken, then predict its events
    task automatic send_item(t_in_item it);
        while (sender_gap()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_events(it);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_POLICY:  m_policy = value[1:0];
            REG_QUANTUM: m_quantum = value[15:0];
            default:     m_pcount = value[4:0];
        endcase
    endtask

    // Drop valid and wait until every expected event is out and the block settles
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        pick = $urandom_range(0, 99);
        it.operation = (pick < 20) ? OP_LOAD : (pick < 75) ? OP_TICK :
                       (pick < 80) ? OP_END : OP_STATS;
        it.task_index = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 70) it.arrival = m_tick + 16'($urandom_range(0, 8));
        else if (pick < 85) it.arrival = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else it.arrival = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 75) it.burst = 16'($urandom_range(0, 5));
        else if (pick < 85) it.burst = 16'hFFFF;
        else it.burst = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic t_row mk_row(logic [1:0] op, logic [3:0] idx, logic [15:0] arr,
                                    logic [15:0] burst, bit lit, logic [2:0] ev);
        t_row r;
        r.op = op;
        r.idx = idx;
        r.arr = arr;
        r.burst = burst;
        r.lit = lit;
        r.lit_ev = ev;
        return r;
    endfunction

    t_row dir_rows[24];

    initial begin
        t_in_item it;
        t_out_item lit_item;
        int n_rand;

        in_ch.valid = 1'b0;
        in_ch.item = '0;
        out_ch.ready = 1'b1;
        for (int i = 0; i < NTASK; i++) begin
            m_arr[i] = 0; m_rem[i] = 0; m_wait[i] = 0; m_end[i] = 0;
            m_ready[i] = 0; m_ring[i] = 0;
        end
        m_tick = 0; m_run = NONE; m_slice = 0; m_slice_done = 1;
        m_head = 0; m_tail = 0; m_stuck = 0;
        m_policy = POL_FCFS; m_quantum = 1; m_pcount = 0;

        // Load every entry before any tick scans the table
        dir_rows[0]  = mk_row(OP_LOAD, 0, 16'd0, 16'd0, 1, EV_LOADED);
        dir_rows[1]  = mk_row(OP_LOAD, 1, 16'd0, 16'hFFFF, 1, EV_LOADED);
        dir_rows[2]  = mk_row(OP_LOAD, 2, 16'hFFFF, 16'd2, 1, EV_LOADED);
        dir_rows[3]  = mk_row(OP_LOAD, 3, 16'd1, 16'd1, 1, EV_LOADED);
        for (int i = 4; i < NTASK; i++)
            dir_rows[i] = mk_row(OP_LOAD, 4'(i), 16'(3 + i), 16'(i), 1, EV_LOADED);
        dir_rows[16] = mk_row(OP_STATS, 2, 0, 0, 1, EV_STATS);
        dir_rows[17] = mk_row(OP_END, 0, 0, 0, 1, EV_RUN_END);
        dir_rows[18] = mk_row(OP_TICK, 0, 0, 0, 0, 0);
        dir_rows[19] = mk_row(OP_TICK, 0, 0, 0, 0, 0);
        dir_rows[20] = mk_row(OP_TICK, 0, 0, 0, 0, 0);
        dir_rows[21] = mk_row(OP_STATS, 0, 0, 0, 0, 0);
        dir_rows[22] = mk_row(OP_LOAD, 1, 16'd2, 16'd1, 0, 0);
        dir_rows[23] = mk_row(OP_END, 0, 0, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: zero burst, longest burst, latest arrival
        write_reg(REG_PCOUNT, 4);
        foreach (dir_rows[k]) begin
            it.operation = dir_rows[k].op;
            it.task_index = dir_rows[k].idx;
            it.arrival = dir_rows[k].arr;
            it.burst = dir_rows[k].burst;
            send_item(it);
            if (dir_rows[k].lit) begin
                lit_item = '0;
                lit_item.event_res = dir_rows[k].lit_ev;
                lit_item.event_task = (dir_rows[k].op == OP_END) ? 4'd0 : dir_rows[k].idx;
                lit_item.last = 1'b1;
                event_q[event_q.size()-1] = lit_item;
            end
        end
        drain();

        // Random phases over policies, slices and table sizes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(REG_POLICY, POL_SRB); write_reg(REG_QUANTUM, 1);
                         write_reg(REG_PCOUNT, 16); idle_mode = 0; hold_req = 1; end
                1: begin write_reg(REG_POLICY, POL_RR); write_reg(REG_QUANTUM, 3);
                         write_reg(REG_PCOUNT, 8); idle_mode = 1; end
                2: begin write_reg(REG_QUANTUM, 0); write_reg(REG_PCOUNT, 16); idle_mode = 2; end
                3: begin write_reg(REG_POLICY, 3); write_reg(REG_PCOUNT, 31); idle_mode = 3; end
                default: begin write_reg(REG_POLICY, POL_RR); write_reg(REG_QUANTUM, 16'hFFFF);
                         write_reg(REG_PCOUNT, 5); idle_mode = 0; end
            endcase
            n_rand = 44;
            for (int j = 0; j < n_rand; j++) send_item(random_item());
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
